// ----- rtl/cbd_pkg.sv -----
`timescale 1ns / 1ps

package cbd_pkg;

	// default width of the chunk size accumulator
	localparam int SizeBitsDefault = 32;

	// framing bytes
	localparam logic [7:0] ByteCr = 8'h0D;
	localparam logic [7:0] ByteLf = 8'h0A;

	// result status codes
	localparam logic [1:0] StFrame   = 2'd0;
	localparam logic [1:0] StPayload = 2'd1;
	localparam logic [1:0] StEnd     = 2'd2;
	localparam logic [1:0] StBad     = 2'd3;

	// decoder phases
	typedef enum logic [2:0] {
		PH_SIZE   = 3'd0,
		PH_LF     = 3'd1,
		PH_DATA   = 3'd2,
		PH_SKIP1  = 3'd3,
		PH_SKIP2  = 3'd4,
		PH_ENDED  = 3'd5,
		PH_FAILED = 3'd6
	} phase_t;

	// one input beat
	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_start;
	} beat_t;

	// one result beat
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [1:0] status;
	} result_t;

	// hex digit decode: valid flag and nibble value
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (b >= 8'h30 && b <= 8'h39) begin
				r = {1'b1, 4'(b - 8'h30)};
			end else if (b >= 8'h61 && b <= 8'h66) begin
				r = {1'b1, 4'(b - 8'h57)};
			end else if (b >= 8'h41 && b <= 8'h46) begin
				r = {1'b1, 4'(b - 8'h37)};
			end
			return r;
		end
	endfunction

endpackage

// ----- rtl/chunked_body_decoder.sv -----
`timescale 1ns / 1ps

// Chunked body decoder: takes a chunked message body one byte per beat and
// gives one result beat per input beat (payload byte plus status).
// Input channel: body_valid / body_ready carry body_byte and body_start;
// body_start high restarts decoding at that byte.
// Output channel: payload_valid / payload_ready carry payload_byte and
// status (0 framing, 1 payload, 2 zero chunk end, 3 malformed stop).
// A byte is taken into the input register, then decoded out of it into the
// result register, which drives the output channel.
// Throughput: one byte per cycle unless payload_ready stalls; decode is a
// single pass of logic between the input and result registers.
// When the receiver stalls, the result register holds, the input register
// still takes one more byte, and body_ready falls only once both are full.
// Reset (arst_n low) empties both registers and returns the decoder to
// reading a size line with a zero count.
module chunked_body_decoder #(
	parameter int SIZE_BITS = cbd_pkg::SizeBitsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       body_valid,
	output logic       body_ready,
	input  logic [7:0] body_byte,
	input  logic       body_start,
	output logic       payload_valid,
	input  logic       payload_ready,
	output logic [7:0] payload_byte,
	output logic [1:0] status
);

	logic             valid_s1;
	cbd_pkg::beat_t   beat_s1;
	logic             valid_q;
	cbd_pkg::result_t result_q;
	cbd_pkg::result_t result_d;
	logic             advance;

	// the input stage moves on when the result register is free or draining
	assign advance    = !valid_q || payload_ready;
	assign body_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body_ready) begin
			valid_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body_ready && body_valid) begin
			beat_s1 <= '{body_byte: body_byte, body_start: body_start};
		end
	end

	// decode and state update
	cbd_core #(
		.SIZE_BITS(SIZE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.beat   (beat_s1),
		.result (result_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_d;
		end
	end

	assign payload_valid = valid_q;
	assign payload_byte  = result_q.payload_byte;
	assign status        = result_q.status;

	// a byte waiting in the input register is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input beat lost while stalled");

	// the input side is open whenever the result register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> body_ready)
		else $error("input stalled with empty result register");

	// only payload beats carry a non-zero byte
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status != cbd_pkg::StPayload |-> payload_byte == 8'd0)
		else $error("non-payload beat carries data");

endmodule

// ----- rtl/cbd_core.sv -----
`timescale 1ns / 1ps

module cbd_core #(
	parameter int SIZE_BITS = cbd_pkg::SizeBitsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  cbd_pkg::beat_t  beat,
	output cbd_pkg::result_t result
);

	cbd_pkg::phase_t        phase_q, phase_cur, phase_nxt;
	logic [SIZE_BITS-1:0]   count_q, count_cur, count_nxt, count_dec;
	logic                   seen_q, seen_cur, seen_nxt;
	logic                   ovf_q, ovf_cur, ovf_nxt;
	logic [4:0]             hex;
	logic                   ovf_digit;

	// a start flag restarts the body before the byte is looked at
	always_comb begin
		if (beat.body_start) begin
			phase_cur = cbd_pkg::PH_SIZE;
			count_cur = '0;
			seen_cur  = 1'b0;
			ovf_cur   = 1'b0;
		end else begin
			phase_cur = phase_q;
			count_cur = count_q;
			seen_cur  = seen_q;
			ovf_cur   = ovf_q;
		end
	end

	assign hex       = cbd_pkg::hex_decode(beat.body_byte);
	assign ovf_digit = ovf_cur || (count_cur[SIZE_BITS-1 -: 4] != 4'd0);
	assign count_dec = count_cur - SIZE_BITS'(1);

	// next state
	always_comb begin
		phase_nxt = phase_cur;
		count_nxt = count_cur;
		seen_nxt  = seen_cur;
		ovf_nxt   = ovf_cur;
		unique case (phase_cur)
			cbd_pkg::PH_SIZE: begin
				if (hex[4]) begin
					seen_nxt = 1'b1;
					ovf_nxt  = ovf_digit;
					if (!ovf_digit) begin
						count_nxt = {count_cur[SIZE_BITS-5:0], hex[3:0]};
					end
				end else if (beat.body_byte == cbd_pkg::ByteCr) begin
					phase_nxt = cbd_pkg::PH_LF;
				end else begin
					phase_nxt = cbd_pkg::PH_FAILED;
				end
			end
			cbd_pkg::PH_LF: begin
				if (beat.body_byte != cbd_pkg::ByteLf || !seen_cur || ovf_cur) begin
					phase_nxt = cbd_pkg::PH_FAILED;
				end else if (count_cur == '0) begin
					phase_nxt = cbd_pkg::PH_ENDED;
				end else begin
					phase_nxt = cbd_pkg::PH_DATA;
				end
			end
			cbd_pkg::PH_DATA: begin
				count_nxt = count_dec;
				if (count_dec == '0) begin
					phase_nxt = cbd_pkg::PH_SKIP1;
				end
			end
			cbd_pkg::PH_SKIP1: begin
				phase_nxt = cbd_pkg::PH_SKIP2;
			end
			cbd_pkg::PH_SKIP2: begin
				phase_nxt = cbd_pkg::PH_SIZE;
				count_nxt = '0;
				seen_nxt  = 1'b0;
				ovf_nxt   = 1'b0;
			end
			cbd_pkg::PH_ENDED: begin
				phase_nxt = cbd_pkg::PH_ENDED;
			end
			default: begin
				phase_nxt = cbd_pkg::PH_FAILED;
			end
		endcase
	end

	// result for this beat
	always_comb begin
		result.payload_byte = 8'd0;
		result.status       = cbd_pkg::StFrame;
		unique case (phase_cur)
			cbd_pkg::PH_SIZE: begin
				if (!hex[4] && beat.body_byte != cbd_pkg::ByteCr) begin
					result.status = cbd_pkg::StBad;
				end
			end
			cbd_pkg::PH_LF: begin
				if (beat.body_byte != cbd_pkg::ByteLf || !seen_cur || ovf_cur) begin
					result.status = cbd_pkg::StBad;
				end else if (count_cur == '0) begin
					result.status = cbd_pkg::StEnd;
				end
			end
			cbd_pkg::PH_DATA: begin
				result.status       = cbd_pkg::StPayload;
				result.payload_byte = beat.body_byte;
			end
			default: begin
				result.status = cbd_pkg::StFrame;
			end
		endcase
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cbd_pkg::PH_SIZE;
			count_q <= '0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
			seen_q  <= seen_nxt;
			ovf_q   <= ovf_nxt;
		end
	end

endmodule
